### src/assert_macros.svh
// assertion macros used by the q table engine top level
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked outside reset
`define SQTE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked during reset as well
`define SQTE_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/sqte_pkg.sv
// types, codes and helper functions of the q table engine
// no dependencies
`timescale 1ns / 1ps
package sqte_pkg;

    localparam logic CMD_CHOOSE = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    localparam logic [1:0] REG_LEARN   = 2'd0;
    localparam logic [1:0] REG_EXPLORE = 2'd1;
    localparam logic [1:0] REG_DISCNT  = 2'd2;

    localparam logic [15:0] LEARN_RST   = 16'd6554;
    localparam logic [15:0] EXPLORE_RST = 16'd3277;
    localparam logic [15:0] DISCNT_RST  = 16'd58982;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_MOD_K,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_EXP_RD,
        ST_EXP_VAL,
        ST_UPD_RN,
        ST_UPD_RH,
        ST_UPD_T,
        ST_UPD_D,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic        done;
        logic [15:0] rem;
    } mod_res_t;

    function automatic logic [3:0] popcount8(logic [7:0] m);
        logic [3:0] c;
        c = '0;
        for (int i = 0; i < 8; i++)
        begin
            c = c + 4'(m[i]);
        end
        return c;
    endfunction

    function automatic logic [2:0] kth_set(logic [7:0] m, logic [2:0] k);
        logic [2:0] sel;
        logic [2:0] left;
        logic       found;
        sel   = '0;
        left  = k;
        found = 1'b0;
        for (int i = 0; i < 8; i++)
        begin
            if (m[i] && !found)
            begin
                if (left == 3'd0)
                begin
                    sel   = 3'(i);
                    found = 1'b1;
                end
                else
                begin
                    left = left - 3'd1;
                end
            end
        end
        return sel;
    endfunction

    // x mod lim for an 8-bit x and a constant lim up to 256, by reciprocal multiply
    function automatic logic [7:0] wrap8(logic [7:0] x, logic [15:0] recip, logic [8:0] lim);
        logic [23:0] prod;
        logic [16:0] back;
        prod = 24'(x) * 24'(recip);
        back = 17'(prod[23:16]) * 17'(lim);
        return 8'(17'(x) - back);
    endfunction

    function automatic logic signed [31:0] sat32(logic signed [36:0] v);
        if (v > 37'sh0_7FFF_FFFF)
        begin
            return 32'sh7FFF_FFFF;
        end
        else if (v < -37'sh0_8000_0000)
        begin
            return 32'sh8000_0000;
        end
        else
        begin
            return v[31:0];
        end
    endfunction

endpackage

### src/sqte_mod.sv
// shared remainder unit, restoring, one quotient bit per cycle
// depends on sqte_pkg
`timescale 1ns / 1ps
module sqte_mod
    import sqte_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] dividend,
    input  logic [16:0] divisor,
    output mod_res_t    res
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [15:0] rem_reg, rem_next;
    logic [15:0] quo_reg, quo_next;
    logic [16:0] div_reg;
    logic [16:0] trial;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[15]};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            if ({1'b0, dividend} < divisor)
            begin
                rem_next  = dividend;
                done_next = 1'b1;
                busy_next = 1'b0;
            end
            else
            begin
                rem_next  = '0;
                quo_next  = dividend;
                cnt_next  = 5'd16;
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            rem_next = (trial >= div_reg) ? 16'(trial - div_reg) : trial[15:0];
            quo_next = {quo_reg[14:0], 1'b0};
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            div_reg <= divisor;
        end
    end

    assign res.done = done_reg;
    assign res.rem  = rem_reg;

endmodule

### src/sqte_mul.sv
// shared fraction multiplier with registered product and round half up
// depends on nothing
`timescale 1ns / 1ps
module sqte_mul
(
    input  logic               clk,
    input  logic signed [34:0] op_a,
    input  logic        [15:0] frac,
    output logic signed [35:0] rnd
);

    logic signed [51:0] prod_reg;
    logic signed [51:0] biased;

    always_ff @(posedge clk)
    begin
        prod_reg <= 52'(op_a * $signed({1'b0, frac}));
    end

    assign biased = prod_reg + 52'sd32768;
    assign rnd    = biased[51:16];

endmodule

### src/sarsa_q_table_engine.sv
// top level of the tabular sarsa engine with epsilon-greedy choice
// depends on sqte_pkg, sqte_mod, sqte_mul and assert_macros.svh
//
// channel  | direction | contents
// s_*      | in        | choose or update item, tuser = cmd
// m_*      | out       | one result per item
// cfg_*    | in        | register writes, index 0..2
//
// after reset a clearing pass over all NUM_STATES*NUM_ACTIONS cells zeroes the table
// update: two table reads and two passes of the multiplier
// greedy choose: one table read and compare per action, over min(8,NUM_ACTIONS) actions
// explore: pick_draw modulo the available count (remainder unit), then one table read
// empty mask: no table read; indexes wrap in the cycle of the input transfer
// input is taken only when idle; a stalled result holds the block in its final state
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sarsa_q_table_engine
    import sqte_pkg::*;
#(
    parameter int NUM_STATES  = 256,
    parameter int NUM_ACTIONS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // state_idx[7:0] action_idx[10:8] avail_mask[18:11] explore_draw[34:19]
    // pick_draw[50:35] reward[82:51] next_state[90:83] next_action[93:91]
    // next_is_final[94] zero[95]
    input  logic [95:0] s_tdata,
    // cmd[0]
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // chosen_action[2:0] explored[3] no_action[4] new_value[36:5] zero[39:37]
    output logic [39:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int DEPTH     = NUM_STATES * NUM_ACTIONS;
    localparam int AW        = $clog2(DEPTH);
    localparam int SW        = $clog2(NUM_STATES);
    localparam int ACW       = $clog2(NUM_ACTIONS);
    localparam int MASK_BITS = (NUM_ACTIONS < 8) ? NUM_ACTIONS : 8;
    localparam logic [7:0] MASK_LIM = 8'((1 << MASK_BITS) - 1);
    localparam int S_LIM     = (NUM_STATES < 256) ? NUM_STATES : 256;
    localparam int A_LIM     = (NUM_ACTIONS < 8) ? NUM_ACTIONS : 8;
    localparam logic [15:0] S_RECIP = 16'((65536 + S_LIM - 1) / S_LIM);
    localparam logic [15:0] A_RECIP = 16'((65536 + A_LIM - 1) / A_LIM);
    localparam logic [8:0]  S_DIV   = 9'(S_LIM);
    localparam logic [8:0]  A_DIV   = 9'(A_LIM);

    state_t state_reg, state_next;

    logic [15:0] learn_reg, explore_reg, discnt_reg;

    logic               cmd_reg;
    logic [7:0]         mask_reg;
    logic [15:0]        expl_reg;
    logic [15:0]        pick_reg;
    logic signed [31:0] reward_reg;
    logic               final_reg;

    logic [SW-1:0]      sw_reg, sw_next;
    logic [ACW-1:0]     aw_reg, aw_next;
    logic [SW-1:0]      nsw_reg, nsw_next;
    logic [ACW-1:0]     naw_reg, naw_next;
    logic [2:0]         idx_reg, idx_next;
    logic               have_reg, have_next;
    logic [2:0]         chosen_reg, chosen_next;
    logic               explored_reg, explored_next;
    logic               none_reg, none_next;
    logic signed [31:0] val_reg, val_next;
    logic signed [31:0] q_reg, q_next;
    logic [AW-1:0]      clr_reg, clr_next;

    logic               m_valid_reg;
    logic [39:0]        m_data_reg;
    logic               out_load;
    logic               accept;

    logic               mem_we, mem_re;
    logic [AW-1:0]      mem_waddr, mem_raddr;
    logic signed [31:0] mem_wdata;
    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] rd_data_reg;

    logic               mod_start;
    logic [15:0]        mod_dividend;
    logic [16:0]        mod_divisor;
    mod_res_t           mod_res;

    logic signed [34:0] mul_a;
    logic [15:0]        mul_frac;
    logic signed [35:0] mul_rnd;

    logic [7:0]         mask_eff;
    logic [3:0]         avail_cnt;
    logic signed [33:0] target;
    logic signed [34:0] diff;
    logic signed [36:0] sum;

    function automatic logic [AW-1:0] cell_addr(logic [SW-1:0] s, logic [AW-1:0] a);
        return AW'(s * NUM_ACTIONS) + a;
    endfunction

    sqte_mod u_mod
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (mod_dividend),
        .divisor  (mod_divisor),
        .res      (mod_res)
    );

    sqte_mul u_mul
    (
        .clk  (clk),
        .op_a (mul_a),
        .frac (mul_frac),
        .rnd  (mul_rnd)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign out_load  = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);

    assign mask_eff  = mask_reg & MASK_LIM;
    assign avail_cnt = popcount8(mask_eff);
    assign target    = 34'(reward_reg) + (final_reg ? 34'd0 : mul_rnd[33:0]);
    assign diff      = 35'(target) - 35'(rd_data_reg);
    assign sum       = 37'(q_reg) + 37'(mul_rnd);

    always_comb
    begin
        state_next    = state_reg;
        sw_next       = sw_reg;
        aw_next       = aw_reg;
        nsw_next      = nsw_reg;
        naw_next      = naw_reg;
        idx_next      = idx_reg;
        have_next     = have_reg;
        chosen_next   = chosen_reg;
        explored_next = explored_reg;
        none_next     = none_reg;
        val_next      = val_reg;
        q_next        = q_reg;
        clr_next      = clr_reg;
        mod_start     = 1'b0;
        mod_dividend  = pick_reg;
        mod_divisor   = 17'(avail_cnt);
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        mem_waddr     = cell_addr(sw_reg, AW'(aw_reg));
        mem_raddr     = cell_addr(sw_reg, AW'(idx_reg));
        mem_wdata     = '0;
        mul_a         = 35'(rd_data_reg);
        mul_frac      = discnt_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    sw_next       = SW'(wrap8(s_tdata[7:0], S_RECIP, S_DIV));
                    aw_next       = ACW'(wrap8({5'd0, s_tdata[10:8]}, A_RECIP, A_DIV));
                    nsw_next      = SW'(wrap8(s_tdata[90:83], S_RECIP, S_DIV));
                    naw_next      = ACW'(wrap8({5'd0, s_tdata[93:91]}, A_RECIP, A_DIV));
                    chosen_next   = '0;
                    explored_next = 1'b0;
                    none_next     = 1'b0;
                    val_next      = '0;
                    have_next     = 1'b0;
                    idx_next      = '0;
                    state_next    = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (cmd_reg == CMD_UPDATE)
                begin
                    state_next = ST_UPD_RN;
                end
                else if (avail_cnt == 4'd0)
                begin
                    none_next  = 1'b1;
                    state_next = ST_DONE;
                end
                else if (expl_reg < explore_reg)
                begin
                    mod_start  = 1'b1;
                    state_next = ST_MOD_K;
                end
                else
                begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_MOD_K:
            begin
                if (mod_res.done)
                begin
                    chosen_next   = kth_set(mask_eff, mod_res.rem[2:0]);
                    explored_next = 1'b1;
                    state_next    = ST_EXP_RD;
                end
            end
            ST_SCAN_RD:
            begin
                mem_re     = 1'b1;
                state_next = ST_SCAN_CMP;
            end
            ST_SCAN_CMP:
            begin
                if (mask_eff[idx_reg] && (!have_reg || rd_data_reg > val_reg))
                begin
                    val_next    = rd_data_reg;
                    chosen_next = idx_reg;
                    have_next   = 1'b1;
                end
                if (idx_reg == 3'(MASK_BITS - 1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + 3'd1;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_EXP_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = cell_addr(sw_reg, AW'(chosen_reg));
                state_next = ST_EXP_VAL;
            end
            ST_EXP_VAL:
            begin
                val_next   = rd_data_reg;
                state_next = ST_DONE;
            end
            ST_UPD_RN:
            begin
                mem_re     = 1'b1;
                mem_raddr  = cell_addr(nsw_reg, AW'(naw_reg));
                state_next = ST_UPD_RH;
            end
            ST_UPD_RH:
            begin
                mem_re     = 1'b1;
                mem_raddr  = cell_addr(sw_reg, AW'(aw_reg));
                mul_a      = 35'(rd_data_reg);
                mul_frac   = discnt_reg;
                state_next = ST_UPD_T;
            end
            ST_UPD_T:
            begin
                q_next     = rd_data_reg;
                mul_a      = diff;
                mul_frac   = learn_reg;
                state_next = ST_UPD_D;
            end
            ST_UPD_D:
            begin
                val_next   = sat32(sum);
                mem_we     = 1'b1;
                mem_wdata  = sat32(sum);
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
            learn_reg   <= LEARN_RST;
            explore_reg <= EXPLORE_RST;
            discnt_reg  <= DISCNT_RST;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_LEARN:   learn_reg   <= cfg_data;
                    REG_EXPLORE: explore_reg <= cfg_data;
                    REG_DISCNT:  discnt_reg  <= cfg_data;
                    default:     ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= s_tuser;
            mask_reg   <= s_tdata[18:11];
            expl_reg   <= s_tdata[34:19];
            pick_reg   <= s_tdata[50:35];
            reward_reg <= s_tdata[82:51];
            final_reg  <= s_tdata[94];
        end
        sw_reg       <= sw_next;
        aw_reg       <= aw_next;
        nsw_reg      <= nsw_next;
        naw_reg      <= naw_next;
        idx_reg      <= idx_next;
        have_reg     <= have_next;
        chosen_reg   <= chosen_next;
        explored_reg <= explored_next;
        none_reg     <= none_next;
        val_reg      <= val_next;
        q_reg        <= q_next;
        if (out_load)
        begin
            m_data_reg <= {3'd0, val_reg, none_reg, explored_reg, chosen_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    `SQTE_ASSERT(a_no_accept_clear, (state_reg == ST_CLEAR) |-> !s_tready, "input taken during clear")
    `SQTE_ASSERT(a_write_states, mem_we |-> (state_reg == ST_CLEAR || state_reg == ST_UPD_D), "stray table write")
    `SQTE_ASSERT(a_load_free, out_load |-> (!m_valid_reg || m_tready), "result overwritten")
    `SQTE_ASSERT(a_accept_start, accept |=> (state_reg == ST_DISPATCH), "accept did not start item")
    `SQTE_ASSERT_RST(a_reset_quiet, !rst_n |-> !m_tvalid, "result valid in reset")

endmodule

### verif/sqte_checker.sv
// checker for the q table engine: watches the stream and register channels,
// predicts each result from its own q table copy and compares field by field
// depends on sqte_pkg
`timescale 1ns / 1ps
module sqte_checker
    import sqte_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [95:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [2:0]         action;
        logic               explored;
        logic               no_action;
        logic signed [31:0] value;
    } outcome_t;

    logic signed [31:0] q_mem [0:2047];
    logic [15:0]        alpha;
    logic [15:0]        epsilon;
    logic [15:0]        gamma;
    outcome_t           outcomes [$];

    assign pending = outcomes.size();

    function automatic logic signed [63:0] scale_round(logic [15:0] f,
                                                        logic signed [63:0] x);
        logic signed [63:0] p;
        p = $signed({48'd0, f}) * x + 64'sd32768;
        return p >>> 16;
    endfunction

    function automatic outcome_t predict_and_learn(logic [95:0] d, logic cmd);
        outcome_t           o;
        logic [7:0]         st;
        logic [7:0]         mask;
        int                 cnt;
        int                 k;
        bit                 have;
        logic signed [63:0] q;
        logic signed [63:0] target;
        logic signed [63:0] v;
        int                 here;
        int                 there;
        o    = '0;
        st   = d[7:0];
        mask = d[18:11];
        if (cmd == CMD_CHOOSE)
        begin
            cnt = $countones(mask);
            if (cnt == 0)
            begin
                o.no_action = 1'b1;
            end
            else if (d[34:19] < epsilon)
            begin
                k = int'(d[50:35]) % cnt;
                o.explored = 1'b1;
                for (int i = 0; i < 8; i++)
                begin
                    if (mask[i])
                    begin
                        if (k == 0)
                        begin
                            o.action = 3'(i);
                            k = -1;
                        end
                        else if (k > 0)
                        begin
                            k--;
                        end
                    end
                end
                o.value = q_mem[{st, o.action}];
            end
            else
            begin
                have = 0;
                for (int i = 0; i < 8; i++)
                begin
                    if (mask[i] && (!have || q_mem[{st, 3'(i)}] > o.value))
                    begin
                        o.value  = q_mem[{st, 3'(i)}];
                        o.action = 3'(i);
                        have     = 1;
                    end
                end
            end
        end
        else
        begin
            here   = int'({st, d[10:8]});
            there  = int'({d[90:83], d[93:91]});
            q      = 64'(q_mem[here]);
            target = 64'($signed(d[82:51]));
            if (!d[94])
            begin
                target += scale_round(gamma, 64'(q_mem[there]));
            end
            v = q + scale_round(alpha, target - q);
            if (v > 64'sh7FFF_FFFF)
            begin
                v = 64'sh7FFF_FFFF;
            end
            else if (v < -64'sh8000_0000)
            begin
                v = -64'sh8000_0000;
            end
            o.value    = v[31:0];
            q_mem[here] = v[31:0];
        end
        return o;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t o;
        if (!rst_n)
        begin
            foreach (q_mem[i])
            begin
                q_mem[i] = '0;
            end
            alpha      = LEARN_RST;
            epsilon    = EXPLORE_RST;
            gamma      = DISCNT_RST;
            outcomes   = {};
            fail_count = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_LEARN:   alpha   = cfg_data;
                    REG_EXPLORE: epsilon = cfg_data;
                    REG_DISCNT:  gamma   = cfg_data;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                if (outcomes.size() == 0)
                begin
                    report("unexpected transfer", m_tdata[31:0], '0);
                end
                else
                begin
                    o = outcomes.pop_front();
                    if (m_tdata[2:0] !== o.action)
                        report("chosen_action", 32'(m_tdata[2:0]), 32'(o.action));
                    if (m_tdata[3] !== o.explored)
                        report("explored", 32'(m_tdata[3]), 32'(o.explored));
                    if (m_tdata[4] !== o.no_action)
                        report("no_action", 32'(m_tdata[4]), 32'(o.no_action));
                    if (m_tdata[36:5] !== o.value)
                        report("new_value", m_tdata[36:5], o.value);
                end
            end
            if (s_tvalid && s_tready)
            begin
                o        = predict_and_learn(s_tdata, s_tuser);
                outcomes = {outcomes, o};
            end
        end
    end

endmodule

### verif/tb.sv
// top of the q table engine testbench: clock, reset, stimulus and verdict
// depends on sqte_pkg, sarsa_q_table_engine and sqte_checker
`timescale 1ns / 1ps
module tb;
    import sqte_pkg::*;

    localparam logic [1:0] REG_NONE = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    int          fail_count;
    int          pending;
    int          cycles = 0;
    int          send_idle = 13;
    int          recv_idle = 87;
    int          hold_off = 0;
    logic [7:0]  hot_state;

    always #1 clk = ~clk;

    sarsa_q_table_engine dut (.*);
    sqte_checker checker_i (.*);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 3000000)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic drain();
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (60) @(posedge clk);
    endtask

    task automatic send_item(logic cmd, logic [7:0] st, logic [2:0] act, logic [7:0] mask,
                             logic [15:0] ed, logic [15:0] pd, logic [31:0] rw,
                             logic [7:0] ns, logic [2:0] na, logic fin);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {1'b0, fin, na, ns, rw, pd, ed, mask, act, st};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic random_item();
        logic [7:0]  st;
        logic [31:0] rw;
        st = ($urandom_range(3) == 0) ? 8'($urandom) : hot_state + 8'($urandom_range(3));
        case ($urandom_range(3))
            0: rw = 32'($urandom);
            1: rw = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: rw = 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
        endcase
        if ($urandom_range(1))
        begin
            send_item(CMD_CHOOSE, st, 3'($urandom), ($urandom_range(15) == 0) ? 8'h00 : 8'($urandom),
                      16'($urandom), 16'($urandom), rw, 8'($urandom), 3'($urandom), 1'($urandom));
        end
        else
        begin
            send_item(CMD_UPDATE, st, 3'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
                      rw, hot_state + 8'($urandom_range(3)), 3'($urandom), $urandom_range(3) == 0);
        end
    endtask

    initial
    begin
        hot_state = 8'd40;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        drain();
        // directed: extremes, both commands, empty mask, wrap-free corners
        send_item(CMD_CHOOSE, 8'd0, 3'd0, 8'h00, 16'd0, 16'd0, '0, '0, '0, '0);
        send_item(CMD_CHOOSE, 8'd255, 3'd7, 8'hFF, 16'hFFFF, 16'hFFFF, '0, '0, '0, '0);
        send_item(CMD_UPDATE, 8'd255, 3'd7, 8'h00, '0, '0, 32'h7FFF_FFFF, 8'd255, 3'd7, 1'b1);
        send_item(CMD_UPDATE, 8'd0, 3'd0, 8'hFF, '0, '0, 32'h8000_0000, 8'd255, 3'd7, 1'b0);
        send_item(CMD_UPDATE, 8'd0, 3'd1, 8'h00, '0, '0, 32'h0001_0000, 8'd0, 3'd0, 1'b0);
        send_item(CMD_CHOOSE, 8'd0, 3'd0, 8'hFF, 16'hFFFF, '0, '0, '0, '0, '0);
        send_item(CMD_CHOOSE, 8'd0, 3'd0, 8'h81, 16'd0, 16'd1, '0, '0, '0, '0);
        send_item(CMD_CHOOSE, 8'd0, 3'd0, 8'h80, 16'd3276, 16'hFFFF, '0, '0, '0, '0);
        send_item(CMD_CHOOSE, 8'd0, 3'd0, 8'h3C, 16'd3277, 16'd5, '0, '0, '0, '0);
        send_item(CMD_CHOOSE, 8'd255, 3'd0, 8'h80, 16'd10, 16'd7, '0, '0, '0, '0);
        s_tvalid <= 1'b0;
        drain();
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: begin write_reg(REG_LEARN, 16'hFFFF); write_reg(REG_EXPLORE, 16'd0);
                          write_reg(REG_DISCNT, 16'hFFFF); end
                1: begin write_reg(REG_LEARN, 16'd0); write_reg(REG_EXPLORE, 16'hFFFF);
                          write_reg(REG_DISCNT, 16'd0); send_idle = 87; recv_idle = 13; end
                2: begin write_reg(REG_LEARN, LEARN_RST); write_reg(REG_EXPLORE, EXPLORE_RST);
                          write_reg(REG_DISCNT, DISCNT_RST); send_idle = 0; recv_idle = 0; end
                3: begin write_reg(REG_LEARN, 16'($urandom)); write_reg(REG_EXPLORE, 16'h8000);
                          write_reg(REG_NONE, 16'h1234); end
                default: begin write_reg(REG_LEARN, 16'($urandom)); write_reg(REG_DISCNT, 16'($urandom));
                         write_reg(REG_EXPLORE, 16'($urandom)); end
            endcase
            cfg_valid <= 1'b0;
            if (phase == 2)
            begin
                hold_off = 400;
            end
            for (int n = 0; n < 310; n++)
            begin
                if (n % 60 == 0)
                begin
                    hot_state = 8'($urandom);
                end
                random_item();
            end
            s_tvalid <= 1'b0;
            drain();
        end
        if (fail_count == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
